/* rtl/core/ffsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    localparam logic [15:0] DEFAULT_TOTAL = 16'd1024;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;

    // one row of the segment table
    typedef struct packed {
        logic [15:0] seg_start;
        logic [15:0] seg_length;
        logic        seg_used;
        logic [15:0] seg_owner;
    } seg_t;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_NOFIT    = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_ZERO     = 3'd4
    } status_t;

endpackage

/* rtl/core/first_fit_segment_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core
// First-fit allocator over an address-ordered segment table with coalescing.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream: s_tuser carries the action (allocate,
//   free by owner id, release all), s_tdata the size and the owner to free.
//   Each request gives exactly one result on the m_* stream: m_tuser is the
//   status, m_tdata the start address, the owner id and the freed size.
//   cfg_valid/cfg_data write total_size, which takes effect at the next
//   release-all; cfg_ready is always high.
//   The table sits in one RAM with registered read data. Release-all, a no-op
//   or a request rejected at once goes straight to the result; otherwise a
//   request scans table entries up to the hit and then moves entries for an
//   insert or a removal. Scanned and moved entries together never exceed
//   the table. One request is in work at a time; the next is taken once the
//   result sits in the output register, even while the receiver stalls it.
//   A second result waits until the first has been taken.
//   After reset the block writes the initial free segment of 1024 units
//   in S_INIT before it accepts the first request.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_core
    import ffsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: total_size
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] request_size, [31:16] owner_to_free
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] start_address, [31:16] owner_id,
                                   // [47:32] freed_size
    output logic [2:0]  m_tuser    // [2:0] status
);

    typedef enum logic [13:0] {
        S_INIT    = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_SCAN_RD = 14'b00000000000100,
        S_SCAN_CK = 14'b00000000001000,
        S_INS_RD  = 14'b00000000010000,
        S_INS_WR  = 14'b00000000100000,
        S_INS_TL  = 14'b00000001000000,
        S_INS_HD  = 14'b00000010000000,
        S_NXT_RD  = 14'b00000100000000,
        S_NXT_CK  = 14'b00001000000000,
        S_MRG_WR  = 14'b00010000000000,
        S_DEL_RD  = 14'b00100000000000,
        S_DEL_WR  = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] total_reg, total_next;
    cnt_t        cnt_reg, cnt_next;
    logic [15:0] nown_reg, nown_next;
    logic        alloc_reg, alloc_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] who_reg, who_next;
    logic [15:0] id_reg, id_next;
    cnt_t        idx_reg, idx_next;
    cnt_t        hit_reg, hit_next;
    cnt_t        dst_reg, dst_next;
    cnt_t        gap_reg, gap_next;
    seg_t        prv_reg, prv_next;
    seg_t        ent_reg, ent_next;
    seg_t        nxt_reg, nxt_next;
    logic        nfree_reg, nfree_next;
    status_t     rstat_reg, rstat_next;
    logic [15:0] raddr_reg, raddr_next;
    logic [15:0] rid_reg, rid_next;
    logic [15:0] rfreed_reg, rfreed_next;
    logic        mval_reg, mval_next;
    logic [47:0] mdata_reg, mdata_next;
    logic [2:0]  muser_reg, muser_next;

    logic        ram_we;
    idx_t        ram_waddr, ram_raddr;
    seg_t        ram_wdata, ram_rdata;
    logic        accept;
    logic [15:0] nown_inc;
    logic        prv_free;
    seg_t        merged;

    ffsa_ram #(
        .WIDTH ($bits(seg_t)),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = mval_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;

    // next owner id, skipping zero on wrap
    assign nown_inc = (nown_reg == 16'hFFFF) ? 16'd1 : nown_reg + 16'd1;

    // coalesced segment for a free: previous, released and next entries
    assign prv_free = (hit_reg != '0) && !prv_reg.seg_used;
    always_comb
    begin
        merged            = ent_reg;
        merged.seg_used   = 1'b0;
        merged.seg_owner  = '0;
        if (prv_free)
        begin
            merged.seg_start  = prv_reg.seg_start;
            merged.seg_length = prv_reg.seg_length + ent_reg.seg_length;
        end
        if (nfree_reg)
        begin
            merged.seg_length = merged.seg_length + nxt_reg.seg_length;
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        cnt_next    = cnt_reg;
        nown_next   = nown_reg;
        alloc_next  = alloc_reg;
        size_next   = size_reg;
        who_next    = who_reg;
        id_next     = id_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        dst_next    = dst_reg;
        gap_next    = gap_reg;
        prv_next    = prv_reg;
        ent_next    = ent_reg;
        nxt_next    = nxt_reg;
        nfree_next  = nfree_reg;
        rstat_next  = rstat_reg;
        raddr_next  = raddr_reg;
        rid_next    = rid_reg;
        rfreed_next = rfreed_reg;
        mval_next   = mval_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[IDX_W-1:0];
        ram_wdata   = ent_reg;
        ram_raddr   = idx_reg[IDX_W-1:0];

        // drop the result once taken
        if (mval_reg && m_tready)
        begin
            mval_next = 1'b0;
        end

        // take a new total size
        if (cfg_valid)
        begin
            total_next = cfg_data;
        end

        unique case (state_reg)
            S_INIT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = '{seg_start: '0, seg_length: total_reg,
                               seg_used: 1'b0, seg_owner: '0};
                cnt_next   = cnt_t'(1);
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    size_next   = s_tdata[15:0];
                    who_next    = s_tdata[31:16];
                    rstat_next  = STAT_OK;
                    raddr_next  = '0;
                    rid_next    = '0;
                    rfreed_next = '0;
                    idx_next    = '0;
                    state_next  = S_DONE;
                    unique case (action_t'(s_tuser))
                        ACT_ALLOC:
                        begin
                            if (s_tdata[15:0] == '0)
                            begin
                                rstat_next = STAT_ZERO;
                            end
                            else
                            begin
                                nown_next  = nown_inc;
                                id_next    = nown_inc;
                                rid_next   = nown_inc;
                                alloc_next = 1'b1;
                                state_next = S_SCAN_RD;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (s_tdata[31:16] == '0)
                            begin
                                rstat_next = STAT_NOTFOUND;
                            end
                            else
                            begin
                                alloc_next = 1'b0;
                                state_next = S_SCAN_RD;
                            end
                        end
                        ACT_RELEASE:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = '{seg_start: '0, seg_length: total_reg,
                                          seg_used: 1'b0, seg_owner: '0};
                            cnt_next  = cnt_t'(1);
                        end
                        default:
                        begin
                            rstat_next = STAT_OK;
                        end
                    endcase
                end
            end

            // issue the read of the next table entry
            S_SCAN_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    rstat_next = alloc_reg ? STAT_NOFIT : STAT_NOTFOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_CK;
                end
            end

            // check the entry; remember it as predecessor on a miss
            S_SCAN_CK:
            begin
                if (alloc_reg && !ram_rdata.seg_used && ram_rdata.seg_length >= size_reg)
                begin
                    ent_next = ram_rdata;
                    hit_next = idx_reg;
                    if (ram_rdata.seg_length == size_reg)
                    begin
                        ram_we              = 1'b1;
                        ram_waddr           = idx_reg[IDX_W-1:0];
                        ram_wdata           = ram_rdata;
                        ram_wdata.seg_used  = 1'b1;
                        ram_wdata.seg_owner = id_reg;
                        raddr_next          = ram_rdata.seg_start;
                        state_next          = S_DONE;
                    end
                    else if (cnt_reg >= cnt_t'(MAX_SEGMENTS))
                    begin
                        rstat_next = STAT_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        dst_next   = cnt_reg;
                        state_next = (cnt_reg > idx_reg + cnt_t'(1)) ? S_INS_RD : S_INS_TL;
                    end
                end
                else if (!alloc_reg && ram_rdata.seg_used && ram_rdata.seg_owner == who_reg)
                begin
                    ent_next    = ram_rdata;
                    hit_next    = idx_reg;
                    rfreed_next = ram_rdata.seg_length;
                    nfree_next  = 1'b0;
                    idx_next    = idx_reg + cnt_t'(1);
                    state_next  = (idx_reg + cnt_t'(1) < cnt_reg) ? S_NXT_RD : S_MRG_WR;
                end
                else
                begin
                    prv_next   = ram_rdata;
                    idx_next   = idx_reg + cnt_t'(1);
                    state_next = S_SCAN_RD;
                end
            end

            // open a gap after the hit: move entries up by one
            S_INS_RD:
            begin
                ram_raddr  = idx_t'(dst_reg - cnt_t'(1));
                state_next = S_INS_WR;
            end

            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = dst_reg[IDX_W-1:0];
                ram_wdata  = ram_rdata;
                dst_next   = dst_reg - cnt_t'(1);
                state_next = (dst_reg - cnt_t'(1) > hit_reg + cnt_t'(1)) ? S_INS_RD : S_INS_TL;
            end

            // write the free remainder behind the new block
            S_INS_TL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_t'(hit_reg + cnt_t'(1));
                ram_wdata  = '{seg_start: ent_reg.seg_start + size_reg,
                               seg_length: ent_reg.seg_length - size_reg,
                               seg_used: 1'b0, seg_owner: '0};
                state_next = S_INS_HD;
            end

            // write the new used block
            S_INS_HD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hit_reg[IDX_W-1:0];
                ram_wdata  = '{seg_start: ent_reg.seg_start, seg_length: size_reg,
                               seg_used: 1'b1, seg_owner: id_reg};
                cnt_next   = cnt_reg + cnt_t'(1);
                raddr_next = ent_reg.seg_start;
                state_next = S_DONE;
            end

            // fetch the successor of the released entry
            S_NXT_RD:
            begin
                state_next = S_NXT_CK;
            end

            S_NXT_CK:
            begin
                nxt_next   = ram_rdata;
                nfree_next = !ram_rdata.seg_used;
                state_next = S_MRG_WR;
            end

            // write the coalesced segment, then close the gap
            S_MRG_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = merged;
                if (prv_free)
                begin
                    ram_waddr = idx_t'(hit_reg - cnt_t'(1));
                    dst_next  = hit_reg;
                    idx_next  = hit_reg + cnt_t'(1) + cnt_t'(nfree_reg);
                end
                else
                begin
                    ram_waddr = hit_reg[IDX_W-1:0];
                    dst_next  = hit_reg + cnt_t'(1);
                    idx_next  = hit_reg + cnt_t'(1) + cnt_t'(nfree_reg);
                end
                gap_next = cnt_t'(prv_free) + cnt_t'(nfree_reg);
                if (!prv_free && !nfree_reg)
                begin
                    state_next = S_DONE;
                end
                else if (hit_reg + cnt_t'(1) + cnt_t'(nfree_reg) < cnt_reg)
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg - (cnt_t'(prv_free) + cnt_t'(nfree_reg));
                    state_next = S_DONE;
                end
            end

            // move entries down over the gap
            S_DEL_RD:
            begin
                state_next = S_DEL_WR;
            end

            S_DEL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg[IDX_W-1:0];
                ram_wdata = ram_rdata;
                dst_next  = dst_reg + cnt_t'(1);
                idx_next  = idx_reg + cnt_t'(1);
                if (idx_reg + cnt_t'(1) < cnt_reg)
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg - gap_reg;
                    state_next = S_DONE;
                end
            end

            // hand the result to the output register when it is free
            S_DONE:
            begin
                if (!mval_reg || m_tready)
                begin
                    mval_next  = 1'b1;
                    mdata_next = {rfreed_reg, rid_reg, raddr_reg};
                    muser_next = rstat_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            total_reg <= DEFAULT_TOTAL;
            cnt_reg   <= cnt_t'(1);
            nown_reg  <= '0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            cnt_reg   <= cnt_next;
            nown_reg  <= nown_next;
            mval_reg  <= mval_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        alloc_reg  <= alloc_next;
        size_reg   <= size_next;
        who_reg    <= who_next;
        id_reg     <= id_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        dst_reg    <= dst_next;
        gap_reg    <= gap_next;
        prv_reg    <= prv_next;
        ent_reg    <= ent_next;
        nxt_reg    <= nxt_next;
        nfree_reg  <= nfree_next;
        rstat_reg  <= rstat_next;
        raddr_reg  <= raddr_next;
        rid_reg    <= rid_next;
        rfreed_reg <= rfreed_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

    // table occupancy stays within the RAM
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) && (cnt_reg <= cnt_t'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    // writes never land past the end of the table plus the insert slot
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} <= cnt_reg))
        else $error("table write beyond segment count");

    // a free of owner zero is rejected at once
    a_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == ACT_FREE && s_tdata[31:16] == '0)
        |=> (state_reg == S_DONE && rstat_reg == STAT_NOTFOUND))
        else $error("free of owner zero not rejected");

    // the owner id never becomes zero once an allocate has run
    a_nown: assert property (@(posedge clk) disable iff (!rst_n)
        (nown_reg != '0) |=> (nown_reg != '0))
        else $error("owner id sequence reached zero");

endmodule

/* rtl/core/ffsa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* tb/sv/first_fit_segment_allocator_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core_test
// Drives allocate, free, release-all and no-op requests with random stalls on both
// streams, predicts each result with an internal model of the segment table
// and checks every result field in order.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_core_test;
    import ffsa_pkg::*;

    // expected result of one request
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] addr;
        logic [15:0] owner;
        logic [15:0] freed;
    } alloc_result_t;

    // segment table model and result checker
    class alloc_scoreboard;
        logic [15:0]   total;
        logic [15:0]   seg_start [MAX_SEGMENTS];
        logic [15:0]   seg_len   [MAX_SEGMENTS];
        bit            seg_used  [MAX_SEGMENTS];
        logic [15:0]   seg_own   [MAX_SEGMENTS];
        int            seg_cnt;
        logic [15:0]   next_id;
        alloc_result_t pending [$];
        int            errors;
        logic [15:0]   live_ids [$];

        function void init_table();
            for (int k = 0; k < MAX_SEGMENTS; k++)
            begin
                seg_start[k] = '0;
                seg_len[k]   = '0;
                seg_used[k]  = 1'b0;
                seg_own[k]   = '0;
            end
            seg_len[0] = total;
            seg_cnt    = 1;
        endfunction

        function void reset_state();
            total   = DEFAULT_TOTAL;
            next_id = '0;
            errors  = 0;
            init_table();
        endfunction

        function void remove_row(int idx);
            for (int k = idx; k + 1 < seg_cnt; k++)
            begin
                seg_start[k] = seg_start[k+1];
                seg_len[k]   = seg_len[k+1];
                seg_used[k]  = seg_used[k+1];
                seg_own[k]   = seg_own[k+1];
            end
            seg_cnt--;
            seg_start[seg_cnt] = '0;
            seg_len[seg_cnt]   = '0;
            seg_used[seg_cnt]  = 1'b0;
            seg_own[seg_cnt]   = '0;
        endfunction

        // apply one accepted request and queue its expected result
        function void note_request(action_t act, logic [15:0] size, logic [15:0] who);
            alloc_result_t r;
            int i;
            r = '0;
            r.status = STAT_OK;
            if (act == ACT_ALLOC)
            begin
                if (size == 16'd0)
                    r.status = STAT_ZERO;
                else
                begin
                    next_id = next_id + 16'd1;
                    if (next_id == 16'd0)
                        next_id = 16'd1;
                    r.owner = next_id;
                    for (i = 0; i < seg_cnt; i++)
                        if (!seg_used[i] && seg_len[i] >= size)
                            break;
                    if (i >= seg_cnt)
                        r.status = STAT_NOFIT;
                    else if (seg_len[i] == size)
                    begin
                        seg_used[i] = 1'b1;
                        seg_own[i]  = next_id;
                        r.addr      = seg_start[i];
                        live_ids.push_back(next_id);
                    end
                    else if (seg_cnt >= MAX_SEGMENTS)
                        r.status = STAT_FULL;
                    else
                    begin
                        for (int k = seg_cnt; k > i + 1; k--)
                        begin
                            seg_start[k] = seg_start[k-1];
                            seg_len[k]   = seg_len[k-1];
                            seg_used[k]  = seg_used[k-1];
                            seg_own[k]   = seg_own[k-1];
                        end
                        seg_start[i+1] = seg_start[i] + size;
                        seg_len[i+1]   = seg_len[i] - size;
                        seg_used[i+1]  = 1'b0;
                        seg_own[i+1]   = '0;
                        seg_len[i]     = size;
                        seg_used[i]    = 1'b1;
                        seg_own[i]     = next_id;
                        seg_cnt++;
                        r.addr = seg_start[i];
                        live_ids.push_back(next_id);
                    end
                end
            end
            else if (act == ACT_FREE)
            begin
                r.status = STAT_NOTFOUND;
                if (who != 16'd0)
                begin
                    for (i = 0; i < seg_cnt; i++)
                        if (seg_used[i] && seg_own[i] == who)
                            break;
                    if (i < seg_cnt)
                    begin
                        r.status    = STAT_OK;
                        r.freed     = seg_len[i];
                        seg_used[i] = 1'b0;
                        seg_own[i]  = '0;
                        if (i > 0 && !seg_used[i-1])
                        begin
                            seg_len[i-1] = seg_len[i-1] + seg_len[i];
                            remove_row(i);
                            i--;
                        end
                        if (i + 1 < seg_cnt && !seg_used[i+1])
                        begin
                            seg_len[i] = seg_len[i] + seg_len[i+1];
                            remove_row(i + 1);
                        end
                    end
                end
            end
            else if (act == ACT_RELEASE)
            begin
                init_table();
                live_ids.delete();
            end
            pending.push_back(r);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(logic [2:0] st, logic [47:0] data);
            alloc_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d data=%h", $time, st, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status exp %0d got %0d", $time, e.status, st);
                errors++;
            end
            if (data[15:0] !== e.addr)
            begin
                $display("%0t: start_address exp %0d got %0d", $time, e.addr, data[15:0]);
                errors++;
            end
            if (data[31:16] !== e.owner)
            begin
                $display("%0t: owner_id exp %0d got %0d", $time, e.owner, data[31:16]);
                errors++;
            end
            if (data[47:32] !== e.freed)
            begin
                $display("%0t: freed_size exp %0d got %0d", $time, e.freed, data[47:32]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    alloc_scoreboard board;
    int  src_idle_pct;
    int  sink_idle_pct;
    bit  sink_hold;

    first_fit_segment_allocator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // hold off or advance the result stream
    always @(negedge clk)
    begin
        if (sink_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // check results
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata);
    end

    // send one request, idling at random before it; the request stays on
    // the bus until the next request or an idle cycle replaces it
    task automatic send_request(action_t act, logic [15:0] size, logic [15:0] who);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {who, size};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_request(act, size, who);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    // write total_size while idle; it takes effect at the next release-all
    task automatic write_total(logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.total = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_owner();
        int n;
        n = board.live_ids.size();
        if (n != 0 && $urandom_range(9) < 8)
            return board.live_ids[$urandom_range(n - 1)];
        return $urandom_range(9) < 5 ? 16'($urandom_range(8)) : 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_size(logic [15:0] tot);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return 16'd0;
        if (r < 8)
            return 16'($urandom);
        if (tot < 16)
            return 16'($urandom_range(1, tot + 1));
        return 16'($urandom_range(1, tot / 6 + 1));
    endfunction

    // one random phase
    task automatic random_phase(int count, logic [15:0] tot);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                send_request(ACT_ALLOC, pick_size(tot), 16'($urandom));
            else if (r < 93)
                send_request(ACT_FREE, 16'($urandom), pick_owner());
            else if (r < 97)
                send_request(ACT_RELEASE, 16'($urandom), 16'($urandom));
            else
                send_request(ACT_NOP, 16'($urandom), 16'($urandom));
        end
    endtask

    // stimulus
    initial
    begin
        logic [15:0] sizes [4];
        board         = new();
        board.reset_state();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = ACT_NOP;
        m_tready      = 1'b0;
        src_idle_pct  = 33;
        sink_idle_pct = 33;
        sink_hold     = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, each action, special cases
        send_request(ACT_ALLOC, 16'd0, 16'hFFFF);
        send_request(ACT_ALLOC, 16'd100, 16'd0);
        send_request(ACT_ALLOC, 16'd1, 16'd0);
        send_request(ACT_ALLOC, 16'hFFFF, 16'd0);
        send_request(ACT_FREE, 16'hFFFF, 16'd0);
        send_request(ACT_FREE, 16'd0, 16'd1);
        send_request(ACT_FREE, 16'd0, 16'd1);
        send_request(ACT_FREE, 16'd0, 16'd2);
        send_request(ACT_ALLOC, 16'd923, 16'd0);
        send_request(ACT_FREE, 16'd0, 16'hFFFF);
        send_request(ACT_NOP, 16'hFFFF, 16'hFFFF);
        send_request(ACT_RELEASE, 16'hFFFF, 16'hFFFF);
        send_request(ACT_ALLOC, 16'd1024, 16'd0);
        send_request(ACT_RELEASE, 16'd0, 16'd0);

        // fill the table: the last split must report full
        for (int k = 0; k < MAX_SEGMENTS + 1; k++)
            send_request(ACT_ALLOC, 16'd1, 16'd0);
        send_request(ACT_RELEASE, 16'd0, 16'd0);

        // zero total size
        write_total(16'd0);
        send_request(ACT_RELEASE, 16'd0, 16'd0);
        send_request(ACT_ALLOC, 16'd1, 16'd0);

        // full pressure with no idling: hold the sink while requests queue
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_total(16'hFFFF);
        send_request(ACT_RELEASE, 16'd0, 16'd0);
        fork
            begin
                sink_hold = 1'b1;
                repeat (400) @(negedge clk);
                sink_hold = 1'b0;
            end
            random_phase(40, 16'hFFFF);
        join
        wait_drained();
        src_idle_pct  = 33;
        sink_idle_pct = 33;

        // random phases over several sizes
        sizes = '{16'd1, 16'd1024, 16'd37, 16'hFFFF};
        for (int p = 0; p < 4; p++)
        begin
            write_total(sizes[p]);
            send_request(ACT_RELEASE, 16'd0, 16'd0);
            random_phase(230, sizes[p]);
        end

        // a tiny table where most allocates fail
        write_total(16'd4);
        send_request(ACT_RELEASE, 16'd0, 16'd0);
        random_phase(40, 16'd4);

        wait_drained();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("first_fit_segment_allocator_core_test: clean");
        else
            $display("first_fit_segment_allocator_core_test: errors");
        $finish;
    end

    // timeout
    initial
    begin
        #5ms;
        $display("first_fit_segment_allocator_core_test: errors");
        $finish;
    end

endmodule
